>>> src/hrf_pkg.sv
package hrf_pkg;

    localparam int CFG_W       = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_LENGTH = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_BAD_METHOD = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_C     = 8'h43;

    // classified byte handed from the front end to the parser
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
    } t_item;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47; // G
            2'd1:    c = 8'h45; // E
            2'd2:    c = 8'h54; // T
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h50; // P
            2'd1:    c = 8'h4F; // O
            2'd2:    c = 8'h53; // S
            2'd3:    c = 8'h54; // T
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Content-Length: "
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            4'd15:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> src/hrf_ifs.sv
interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       message_start;
    logic       message_end;
    logic       in_body;
    logic [1:0] status;

    modport source (output valid, output byte_out, output byte_valid, output message_start,
                    output message_end, output in_body, output status, input ready);
    modport sink   (input valid, input byte_out, input byte_valid, input message_start,
                    input message_end, input in_body, input status, output ready);
endinterface

interface hrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/hrf_front.sv
module hrf_front
    import hrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrf_in_if.sink     i_in,
    output logic       o_item_valid,
    input  logic       i_item_ready,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign i_in.ready = !r_valid || i_item_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_item.restart  = i_in.restart;
        n_item.data     = i_in.data_byte;
        n_item.is_digit = (i_in.data_byte >= CH_ZERO) && (i_in.data_byte <= CH_NINE);
        n_item.digit    = i_in.data_byte[3:0];
        n_item.is_cr    = i_in.data_byte == CH_CR;
        n_item.is_lf    = i_in.data_byte == CH_LF;
        n_item.is_space = i_in.data_byte == CH_SPACE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> src/hrf_queue.sv
module hrf_queue
    import hrf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != CW'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

>>> src/hrf_back.sv
module hrf_back
    import hrf_pkg::*;
#(
    parameter int LEN_BITS = 24
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    output logic       o_item_ready,
    input  t_item      i_item,
    hrf_cfg_if.sink    i_cfg,
    hrf_out_if.source  o_res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_METHOD = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;

    localparam logic [4:0] HN_NAME_LAST = 5'd15;
    localparam logic [4:0] HN_SKIP      = 5'd16;
    localparam logic [4:0] HN_DIGITS    = 5'd17;
    localparam logic [4:0] HN_DONE      = 5'd18;

    localparam int LW = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
    localparam int AW = LEN_BITS + 4;
    localparam logic [LW-1:0] CAP = LW'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [LW-1:0] CFG_RESET = LW'(24'hFFFFFF);
    localparam logic [LEN_BITS-1:0] LIMIT_RESET =
        (CFG_RESET < CAP) ? CFG_RESET[LEN_BITS-1:0] : CAP[LEN_BITS-1:0];

    logic [LEN_BITS-1:0] r_limit;
    logic [LW-1:0]       cfg_ext;

    logic [2:0]          r_phase,   n_phase;
    logic [2:0]          r_mm,      n_mm;
    logic                r_is_post, n_is_post;
    logic [2:0]          r_blm,     n_blm;
    logic [4:0]          r_hnm,     n_hnm;
    logic                r_len_seen, n_len_seen;
    logic [LEN_BITS-1:0] r_acc,     n_acc;
    logic [LEN_BITS-1:0] r_br,      n_br;

    logic                r_out_valid;
    logic [7:0]          r_byte,   n_byte;
    logic                r_bvalid, n_bvalid;
    logic                r_start,  n_start;
    logic                r_end,    n_end;
    logic                r_body,   n_body;
    logic [1:0]          r_status, n_status;

    logic                pop;
    logic                fail;
    logic [1:0]          fail_code;
    logic [AW-1:0]       acc_next;
    logic [7:0]          want;

    assign i_cfg.ready  = 1'b1;
    assign cfg_ext      = LW'(i_cfg.data);
    assign o_item_ready = !r_out_valid || o_res.ready;
    assign pop          = i_item_valid && o_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= (cfg_ext < CAP) ? cfg_ext[LEN_BITS-1:0] : CAP[LEN_BITS-1:0];
        end
    end

    // acc * 10 + digit, wide enough that it never wraps
    assign acc_next = AW'({r_acc, 3'b000}) + AW'({r_acc, 1'b0}) + AW'(i_item.digit);
    assign want     = r_is_post ? post_char(r_mm[1:0]) : get_char(r_mm[1:0]);

    always_comb begin
        n_phase    = r_phase;
        n_mm       = r_mm;
        n_is_post  = r_is_post;
        n_blm      = r_blm;
        n_hnm      = r_hnm;
        n_len_seen = r_len_seen;
        n_acc      = r_acc;
        n_br       = r_br;
        n_byte     = i_item.data;
        n_bvalid   = 1'b1;
        n_start    = 1'b0;
        n_end      = 1'b0;
        n_body     = 1'b0;
        n_status   = ST_OK;
        fail       = 1'b0;
        fail_code  = ST_OK;

        if (i_item.restart) begin
            n_phase    = PH_IDLE;
            n_mm       = '0;
            n_is_post  = 1'b0;
            n_blm      = '0;
            n_hnm      = '0;
            n_len_seen = 1'b0;
            n_acc      = '0;
            n_br       = '0;
            n_bvalid   = 1'b0;
        end else if (r_phase[2]) begin
            // sticky error: drop and repeat the code
            n_bvalid = 1'b0;
            n_status = r_phase[1:0];
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_blm      = '0;
                    n_hnm      = '0;
                    n_len_seen = 1'b0;
                    n_acc      = '0;
                    n_br       = '0;
                    n_mm       = 3'd1;
                    n_phase    = PH_METHOD;
                    n_start    = 1'b1;
                    if (i_item.data == CH_G) begin
                        n_is_post = 1'b0;
                    end else if (i_item.data == CH_P) begin
                        n_is_post = 1'b1;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (i_item.data != want) begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_METHOD;
                    end else begin
                        n_mm = r_mm + 3'd1;
                        if (n_mm == (r_is_post ? 3'd4 : 3'd3)) begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_HEADER: begin
                    if (r_is_post) begin
                        if (!r_len_seen) begin
                            if (r_hnm <= HN_NAME_LAST &&
                                i_item.data == name_char(r_hnm[3:0])) begin
                                n_hnm = r_hnm + 5'd1;
                                if (r_hnm == HN_NAME_LAST) begin
                                    n_len_seen = 1'b1;
                                end
                            end else begin
                                n_hnm = (i_item.data == CH_C) ? 5'd1 : 5'd0;
                            end
                        end else if (r_hnm == HN_SKIP || r_hnm == HN_DIGITS) begin
                            if (i_item.is_digit) begin
                                n_acc = acc_next[LEN_BITS-1:0];
                                n_hnm = HN_DIGITS;
                                if (acc_next > AW'(r_limit)) begin
                                    fail      = 1'b1;
                                    fail_code = ST_TOO_LONG;
                                end
                            end else if (!(i_item.is_space && r_hnm == HN_SKIP)) begin
                                n_hnm = HN_DONE;
                            end
                        end
                    end
                    if (i_item.is_cr) begin
                        n_blm = (r_blm == 3'd2) ? 3'd3 : 3'd1;
                    end else if (i_item.is_lf && (r_blm == 3'd1 || r_blm == 3'd3)) begin
                        n_blm = r_blm + 3'd1;
                    end else begin
                        n_blm = '0;
                    end
                    if (n_blm == 3'd4 && !fail) begin
                        if (!r_is_post) begin
                            n_end = 1'b1;
                        end else if (!r_len_seen) begin
                            fail      = 1'b1;
                            fail_code = ST_NO_LENGTH;
                        end else if (r_acc == '0) begin
                            n_end = 1'b1;
                        end else begin
                            n_br    = r_acc;
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_body = 1'b1;
                    n_br   = r_br - LEN_BITS'(1);
                    if (r_br == LEN_BITS'(1)) begin
                        n_end = 1'b1;
                    end
                end
                default: begin
                    n_bvalid = 1'b0;
                end
            endcase

            if (n_end) begin
                n_phase = PH_IDLE;
            end
            if (fail) begin
                n_phase  = {1'b1, fail_code};
                n_start  = 1'b0;
                n_end    = 1'b0;
                n_body   = 1'b0;
                n_bvalid = 1'b0;
                n_status = fail_code;
            end
        end

        if (!n_bvalid) begin
            n_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mm        <= '0;
            r_is_post   <= 1'b0;
            r_blm       <= '0;
            r_hnm       <= '0;
            r_len_seen  <= 1'b0;
            r_acc       <= '0;
            r_br        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase    <= n_phase;
                r_mm       <= n_mm;
                r_is_post  <= n_is_post;
                r_blm      <= n_blm;
                r_hnm      <= n_hnm;
                r_len_seen <= n_len_seen;
                r_acc      <= n_acc;
                r_br       <= n_br;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_byte   <= n_byte;
            r_bvalid <= n_bvalid;
            r_start  <= n_start;
            r_end    <= n_end;
            r_body   <= n_body;
            r_status <= n_status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.byte_out      = r_byte;
    assign o_res.byte_valid    = r_bvalid;
    assign o_res.message_start = r_start;
    assign o_res.message_end   = r_end;
    assign o_res.in_body       = r_body;
    assign o_res.status        = r_status;

    a_err_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (!r_bvalid && !r_start && !r_end && !r_body))
        else $error("error result passes a byte");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_br != '0))
        else $error("body phase with no bytes left");

    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_item.restart) |=> (r_phase == PH_IDLE && r_out_valid && !r_bvalid))
        else $error("restart did not return the parser to idle");

    a_acc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER && r_len_seen) |-> (r_acc <= r_limit))
        else $error("accepted length above limit");

endmodule

>>> src/http_request_framer_unit.sv
// HTTP request framer: frames request messages in one connection's byte stream at one byte
// per cycle sustained while the output is not stalled, one result per input byte, in order.
// A byte crosses a classify register, a two-entry queue and the output register, in that
// order; the queue lets the input side keep transferring while the output side is briefly
// held. The rate is set by the parser's combinational length step (multiply by ten, add
// the digit, compare with the limit).
// GET ends at the blank line, POST ends Content-Length body bytes after it; errors
// (status 1..3) drop every byte until a restart item. max_content_length may be written
// only while no bytes are in flight; its port is always ready. LEN_BITS sizes the length
// counters and caps the limit at 2^LEN_BITS-1.
module http_request_framer_unit
    import hrf_pkg::*;
#(
    parameter int LEN_BITS = 24
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrf_in_if.sink    i_in,
    hrf_cfg_if.sink   i_cfg,
    hrf_out_if.source o_out
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    hrf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    hrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    hrf_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .i_cfg        (i_cfg),
        .o_res        (o_out)
    );

endmodule

>>> tb/sv/tb_http_request_framer_unit.sv
`timescale 1ns / 100ps

module tb_http_request_framer_unit;
    import hrf_pkg::*;

    // one input byte of the connection stream
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } t_stream_item;

    // framing of one byte as the block reports it
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       start;
        logic       last;
        logic       body;
        logic [1:0] status;
    } t_framed;

    typedef enum logic [2:0] {FR_IDLE, FR_METHOD, FR_HEADER, FR_BODY, FR_FAIL} t_fr_phase;
    typedef enum int {PK_OK, PK_NOLEN, PK_OVER, PK_FULL} t_post_kind;

    localparam int NAME_SKIP   = 16;
    localparam int NAME_DIGITS = 17;
    localparam int NAME_DONE   = 18;

    localparam logic [8*3-1:0]  GET_TXT  = "GET";
    localparam logic [8*4-1:0]  POST_TXT = "POST";
    localparam logic [8*16-1:0] NAME_TXT = "Content-Length: ";

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic        in_valid   = 1'b0;
    logic [7:0]  in_data    = 8'h00;
    logic        in_restart = 1'b0;
    logic        out_ready  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [23:0] cfg_data   = 24'h000000;

    hrf_in_if  in_if ();
    hrf_cfg_if cfg_if ();
    hrf_out_if out_if ();

    assign in_if.valid     = in_valid;
    assign in_if.data_byte = in_data;
    assign in_if.restart   = in_restart;
    assign out_if.ready    = out_ready;
    assign cfg_if.valid    = cfg_valid;
    assign cfg_if.data     = cfg_data;

    http_request_framer_unit #(
        .LEN_BITS(24)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    t_stream_item pending_q[$];
    t_framed      framed_due[$];

    int unsigned fail_cnt  = 0;
    int unsigned added_cnt = 0;
    logic [23:0] gen_limit = 24'hFFFFFF;

    bit          in_xfer = 1'b0;
    bit          in_busy = 1'b0;
    int unsigned in_gap  = 0;
    int unsigned in_calm = 0;
    int unsigned out_stall = 0;
    int unsigned out_calm  = 0;

    // framer state
    t_fr_phase       fr_phase;
    logic [1:0]      fr_code;
    int unsigned     fr_meth;
    bit              fr_post;
    int unsigned     fr_crlf;
    int unsigned     fr_name;
    bit              fr_len_seen;
    longint unsigned fr_len;
    longint unsigned fr_left;
    logic [23:0]     fr_limit;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void clear_frame_state();
        fr_phase    = FR_IDLE;
        fr_code     = ST_OK;
        fr_meth     = 0;
        fr_post     = 1'b0;
        fr_crlf     = 0;
        fr_name     = 0;
        fr_len_seen = 1'b0;
        fr_len      = 0;
        fr_left     = 0;
    endfunction

    function automatic t_framed fail_with(input logic [1:0] code);
        t_framed r;
        r        = '0;
        r.status = code;
        fr_phase = FR_FAIL;
        fr_code  = code;
        return r;
    endfunction

    function automatic t_framed frame_byte(input logic [7:0] b, input logic rs);
        t_framed     r;
        bit          start_f;
        bit          end_f;
        bit          body_f;
        bit          digit;
        int unsigned mlen;
        logic [7:0]  want;
        r       = '0;
        start_f = 1'b0;
        end_f   = 1'b0;
        body_f  = 1'b0;
        digit   = (b >= CH_ZERO) && (b <= CH_NINE);
        if (rs) begin
            clear_frame_state();
            return r;
        end
        if (fr_phase == FR_FAIL) begin
            r.status = fr_code;
            return r;
        end
        case (fr_phase)
            FR_IDLE: begin
                clear_frame_state();
                if (b == CH_G) fr_post = 1'b0;
                else if (b == CH_P) fr_post = 1'b1;
                else return fail_with(ST_BAD_METHOD);
                fr_meth  = 1;
                fr_phase = FR_METHOD;
                start_f  = 1'b1;
            end
            FR_METHOD: begin
                mlen = fr_post ? 4 : 3;
                want = fr_post ? POST_TXT[8*(3-fr_meth) +: 8] : GET_TXT[8*(2-fr_meth) +: 8];
                if (b != want) return fail_with(ST_BAD_METHOD);
                fr_meth++;
                if (fr_meth == mlen) fr_phase = FR_HEADER;
            end
            FR_HEADER: begin
                if (fr_post) begin
                    if (!fr_len_seen) begin
                        if (b == NAME_TXT[8*(15-fr_name) +: 8]) begin
                            fr_name++;
                            if (fr_name == 16) fr_len_seen = 1'b1;
                        end else begin
                            // a C may open a new match
                            fr_name = (b == CH_C) ? 1 : 0;
                        end
                    end else if (fr_name == NAME_SKIP || fr_name == NAME_DIGITS) begin
                        if (digit) begin
                            fr_len  = fr_len * 10 + (b - CH_ZERO);
                            fr_name = NAME_DIGITS;
                            if (fr_len > fr_limit) return fail_with(ST_TOO_LONG);
                        end else if (!(b == CH_SPACE && fr_name == NAME_SKIP)) begin
                            fr_name = NAME_DONE;
                        end
                    end
                end
                if (b == CH_CR) fr_crlf = (fr_crlf == 2) ? 3 : 1;
                else if (b == CH_LF && (fr_crlf == 1 || fr_crlf == 3)) fr_crlf++;
                else fr_crlf = 0;
                if (fr_crlf == 4) begin
                    if (!fr_post) begin
                        end_f = 1'b1;
                    end else if (!fr_len_seen) begin
                        return fail_with(ST_NO_LENGTH);
                    end else if (fr_len == 0) begin
                        end_f = 1'b1;
                    end else begin
                        fr_left  = fr_len;
                        fr_phase = FR_BODY;
                    end
                end
            end
            default: begin
                body_f = 1'b1;
                if (fr_left > 0) fr_left--;
                if (fr_left == 0) end_f = 1'b1;
            end
        endcase
        if (end_f) fr_phase = FR_IDLE;
        r.data   = b;
        r.valid  = 1'b1;
        r.start  = start_f;
        r.last   = end_f;
        r.body   = body_f;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic string show_frame(input t_framed f);
        return $sformatf("byte=%h valid=%b start=%b end=%b body=%b status=%0d",
                         f.data, f.valid, f.start, f.last, f.body, f.status);
    endfunction

    function automatic int unsigned send_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned stall_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // input driver
    always @(negedge i_clk) begin : driver
        t_stream_item it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_busy = 1'b0;
        end else if (!in_busy || in_xfer) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
                in_busy = 1'b0;
            end else if (pending_q.size() > 0) begin
                it = pending_q.pop_front();
                in_valid   <= 1'b1;
                in_data    <= it.data;
                in_restart <= it.restart;
                in_busy = 1'b1;
                if (in_calm > 0) in_calm--;
                else if ($urandom_range(0, 99) < 2) in_calm = $urandom_range(20, 80);
                in_gap = (in_calm > 0) ? 0 : send_gap();
            end else begin
                in_valid <= 1'b0;
                in_busy = 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (out_calm > 0) out_calm--;
            else if ($urandom_range(0, 99) < 2) out_calm = $urandom_range(30, 100);
            else if ($urandom_range(0, 99) < 20) out_stall = stall_len();
        end
    end

    always @(posedge i_clk) begin : monitor
        t_framed got;
        t_framed want;
        if (!i_rst_n) begin
            clear_frame_state();
            fr_limit = 24'hFFFFFF;
            in_xfer  = 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) fr_limit = cfg_if.data;
            in_xfer = in_if.valid && in_if.ready;
            if (in_xfer) framed_due.push_back(frame_byte(in_if.data_byte, in_if.restart));
            if (out_if.valid && out_if.ready) begin
                got = {out_if.byte_out, out_if.byte_valid, out_if.message_start,
                       out_if.message_end, out_if.in_body, out_if.status};
                if (framed_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected result: %s", show_frame(got));
                end else begin
                    want = framed_due.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch at %0t", $time);
                            $display("  expected %s", show_frame(want));
                            $display("  actual   %s", show_frame(got));
                        end
                    end
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        pending_q.push_back('{data: b, restart: 1'b0});
        added_cnt++;
    endtask

    task automatic add_restart();
        // data byte rides along and is ignored
        pending_q.push_back('{data: 8'($urandom_range(0, 255)), restart: 1'b1});
        added_cnt++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_filler(input int unsigned n);
        repeat (n) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    task automatic add_noise(input longint unsigned n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_decimal(input longint unsigned v);
        add_text($sformatf("%0d", v));
    endtask

    task automatic gen_get();
        add_text("GET");
        if ($urandom_range(0, 3) != 0) begin
            add_text(" /");
            add_filler($urandom_range(0, 6));
        end
        add_crlf();
        repeat ($urandom_range(0, 2)) begin
            // a length header on a GET is not framed
            if ($urandom_range(0, 4) == 0) begin
                add_text("Content-Length: ");
                add_decimal($urandom_range(1, 50));
            end else begin
                add_filler($urandom_range(1, 6));
                add_text(": ");
                add_filler($urandom_range(0, 5));
            end
            add_crlf();
        end
        add_crlf();
    endtask

    task automatic gen_post(input t_post_kind kind);
        longint unsigned len;
        len = 0;
        add_text("POST");
        if ($urandom_range(0, 2) != 0) begin
            add_text(" /");
            add_filler($urandom_range(0, 5));
        end
        add_crlf();
        if ($urandom_range(0, 2) == 0) begin
            add_filler($urandom_range(1, 4));
            add_text(": ");
            add_filler($urandom_range(1, 4));
            add_crlf();
        end
        if (kind == PK_NOLEN) begin
            case ($urandom_range(0, 3))
                0:       add_text("content-length: 5");
                1:       add_text("Content-Length:5");
                2:       add_text("Content-Length 5");
                default: add_filler($urandom_range(1, 5));
            endcase
            add_crlf();
        end else begin
            case (kind)
                PK_OK: begin
                    len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 12)
                                                       : $urandom_range(13, 60);
                    if (len > gen_limit) len = gen_limit;
                end
                PK_OVER: begin
                    if (gen_limit == 24'hFFFFFF) len = $urandom_range(99999999, 16777216);
                    else len = gen_limit + 1 + $urandom_range(0, 1000);
                end
                default: len = gen_limit;
            endcase
            case ($urandom_range(0, 5))
                0:       add_text("CContent-Length: ");
                1:       add_text("Content-LenContent-Length: ");
                default: add_text("Content-Length: ");
            endcase
            repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
            if (len == 0 && $urandom_range(0, 2) == 0) begin
                // value without digits counts as zero
                if ($urandom_range(0, 1) != 0) add_text("x");
            end else begin
                repeat ($urandom_range(0, 1)) add_byte(CH_ZERO);
                add_decimal(len);
            end
            case ($urandom_range(0, 3))
                0:       add_text(" 7");
                1:       add_text(";q");
                default: ;
            endcase
            add_crlf();
            if ($urandom_range(0, 3) == 0) begin
                add_text("Content-Length: 9");
                add_crlf();
            end
        end
        add_crlf();
        case (kind)
            PK_OK: begin
                if (len >= 17 && $urandom_range(0, 3) == 0) begin
                    add_text("Content-Length: ");
                    add_noise(len - 16);
                end else begin
                    add_noise(len);
                end
            end
            PK_FULL: begin
                if (len <= 80) begin
                    add_noise(len);
                end else begin
                    // cut the body short
                    add_noise($urandom_range(0, 6));
                    add_restart();
                end
            end
            default: begin
                add_noise($urandom_range(0, 4));
                add_restart();
            end
        endcase
    endtask

    task automatic gen_bad();
        case ($urandom_range(0, 4))
            0: add_byte(8'($urandom_range(0, 255)));
            1: add_text("PUT");
            2: add_text("HEAD");
            3: begin
                add_text("GE");
                add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                add_text("PO");
                add_byte(8'($urandom_range(0, 255)));
            end
        endcase
        add_noise($urandom_range(0, 4));
        add_restart();
    endtask

    task automatic gen_cut();
        int unsigned base;
        int unsigned cut;
        base = pending_q.size();
        if ($urandom_range(0, 1) != 0) gen_get();
        else gen_post(PK_OK);
        cut = $urandom_range(base + 1, pending_q.size() - 1);
        while (pending_q.size() > cut) void'(pending_q.pop_back());
        add_restart();
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned start_cnt;
        int unsigned r;
        start_cnt = added_cnt;
        add_restart();
        while (added_cnt - start_cnt < n) begin
            if ($urandom_range(0, 99) < 8) add_restart();
            r = $urandom_range(0, 99);
            if (r < 28) gen_get();
            else if (r < 62) gen_post(PK_OK);
            else if (r < 69) gen_post(PK_NOLEN);
            else if (r < 76) gen_post(PK_OVER);
            else if (r < 82) gen_post(PK_FULL);
            else if (r < 90) gen_bad();
            else gen_cut();
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_busy || framed_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [23:0] v);
        drain();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        gen_limit = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte 00 as a method, then FF while in the error, then the shortest messages
        add_byte(8'h00);
        add_byte(8'hFF);
        add_restart();
        add_text("GET");
        add_crlf();
        add_crlf();
        add_text("POST");
        add_crlf();
        add_crlf();
        add_restart();

        random_phase(300);
        write_limit(24'h000000);
        random_phase(230);
        write_limit(24'hFFFFFF);
        random_phase(230);
        write_limit(24'($urandom_range(1, 40)));
        random_phase(230);
        write_limit(24'($urandom_range(100, 16777214)));
        random_phase(230);
        write_limit(24'($urandom_range(41, 400)));
        random_phase(230);

        drain();
        if (fail_cnt == 0 && framed_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
